// File: hdl/btff_pkg.sv
// Shared types and constants of the boundary-tag first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package btff_pkg;

  localparam int unsigned HeapBytes = 1024;
  localparam int unsigned AddrW     = $clog2(HeapBytes);
  localparam int unsigned RegionW   = 11;
  localparam int unsigned TagBytes  = 4;
  localparam int unsigned Overhead  = 8;
  localparam int unsigned SplitMin  = 8;
  localparam int unsigned RegionMin = 16;
  localparam int unsigned ArithW    = 34;

  // Operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CHECK = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_BADPTR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_RD,
    ST_WR,
    ST_EMIT
  } state_e;

  // Step of the running operation; in ST_EVAL it names the step that is carried out next
  typedef enum logic [4:0] {
    PH_FMT_H,
    PH_FMT_F,
    PH_FMT_D,
    PH_AL_NEXT,
    PH_AL_T,
    PH_AL_W1,
    PH_AL_W2,
    PH_AL_W3,
    PH_AL_X1,
    PH_AL_X2,
    PH_PV_GO,
    PH_PV_H,
    PH_PV_F,
    PH_FR_P,
    PH_FR_NG,
    PH_FR_N,
    PH_FR_W0,
    PH_FR_W1,
    PH_FR_D
  } phase_e;

endpackage
`default_nettype wire

// File: hdl/boundary_tag_first_fit_allocator.sv
// Top level: boundary-tag first-fit heap manager over a 1024-byte store.
// Tags are 32 bits wide and are read and written a byte at a time.
//   Allocate walks the blocks, then writes tags for a whole block or a split; free and
//   check first read and validate the tags. One request in flight.
// The single-port byte memory sets the rate. A result waits in an output register.
// Reset (asynchronous, active low) starts a clearing pass over every byte of the store,
//   then formats one free block; requests are refused until then.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // func[1:0], req_size[11:2], block_offset[21:12]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // result_offset[9:0], status[11:10]
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i
);

  localparam int unsigned AW = btff_pkg::AddrW;
  localparam int unsigned RW = btff_pkg::RegionW;
  localparam int unsigned XW = btff_pkg::ArithW;

  // Byte store
  logic [7:0]    mem_q [btff_pkg::HeapBytes];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  // Sequencer state
  btff_pkg::state_e st_q, st_d;
  btff_pkg::phase_e ph_q, ph_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   tag_q, tag_d;
  logic [RW-1:0] h_q, h_d, s_q, s_d, e_q, e_d, t_q, t_d;
  logic [9:0]    sz_q, sz_d;
  logic [1:0]    op_q, op_d;
  logic [9:0]    res_q, res_d;
  logic [1:0]    stat_q, stat_d;
  logic [RW-1:0] region_q, region_d;
  logic          pend_q, pend_d;
  logic          ov_q, ov_d;
  logic [9:0]    ores_q, ores_d;
  logic [1:0]    ostat_q, ostat_d;

  logic          in_acc;
  logic [1:0]    in_func;
  logic [9:0]    in_size, in_off;

  assign in_func = s_axis_tdata[1:0];
  assign in_size = s_axis_tdata[11:2];
  assign in_off  = s_axis_tdata[21:12];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, ostat_q, ores_q};

  // Next state and datapath registers
  always_comb begin
    logic signed [XW-1:0] tv, mag, h34, s34, e34, r34, sz34, t34, diff;
    st_d = st_q; ph_d = ph_q; cnt_d = cnt_q; addr_d = addr_q; clr_d = clr_q;
    tag_d = tag_q; h_d = h_q; s_d = s_q; e_d = e_q; t_d = t_q; sz_d = sz_q;
    op_d = op_q; res_d = res_q; stat_d = stat_q; region_d = region_q;
    pend_d = pend_q; ov_d = ov_q; ores_d = ores_q; ostat_d = ostat_q;
    tv   = {{(XW-32){tag_q[31]}}, tag_q};
    mag  = tag_q[31] ? -tv : tv;
    h34  = XW'(h_q);
    s34  = XW'(s_q);
    e34  = XW'(e_q);
    r34  = XW'(region_q);
    sz34 = XW'(sz_q);
    t34  = XW'(t_q);
    diff = t34 - sz34 - XW'(btff_pkg::Overhead);

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (st_q)
      btff_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) st_d = btff_pkg::ST_IDLE;
      end
      btff_pkg::ST_IDLE: begin
        if (pend_q) begin
          pend_d = 1'b0;
          ph_d   = btff_pkg::PH_FMT_H;
          st_d   = btff_pkg::ST_EVAL;
        end else if (in_acc) begin
          op_d  = in_func;
          sz_d  = in_size;
          res_d = '0;
          st_d  = btff_pkg::ST_EVAL;
          unique case (in_func)
            btff_pkg::FUNC_ALLOC: begin
              h_d  = '0;
              ph_d = btff_pkg::PH_AL_NEXT;
              if (in_size == '0) begin
                stat_d = btff_pkg::STAT_NOFIT;
                st_d   = btff_pkg::ST_EMIT;
              end
            end
            btff_pkg::FUNC_FREE, btff_pkg::FUNC_CHECK: begin
              h_d  = RW'(in_off) - RW'(btff_pkg::TagBytes);
              ph_d = btff_pkg::PH_PV_GO;
              if (in_off < 10'(btff_pkg::TagBytes)) begin
                stat_d = btff_pkg::STAT_BADPTR;
                st_d   = btff_pkg::ST_EMIT;
              end
            end
            default: begin
              stat_d = btff_pkg::STAT_BADPTR;
              st_d   = btff_pkg::ST_EMIT;
            end
          endcase
        end
      end
      btff_pkg::ST_RD: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q != 3'd0) tag_d = {rdata_q, tag_q[31:8]};
        if (cnt_q == 3'd4) st_d = btff_pkg::ST_EVAL;
      end
      btff_pkg::ST_WR: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) st_d = btff_pkg::ST_EVAL;
      end
      btff_pkg::ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          ores_d  = res_q;
          ostat_d = stat_q;
          st_d    = btff_pkg::ST_IDLE;
        end
      end
      btff_pkg::ST_EVAL: begin
        cnt_d = '0;
        unique case (ph_q)
          // Format: one free block over the region
          btff_pkg::PH_FMT_H: begin
            addr_d = '0;
            tag_d  = 32'(region_q - RW'(btff_pkg::Overhead));
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_FMT_F;
          end
          btff_pkg::PH_FMT_F: begin
            addr_d = AW'(region_q - RW'(btff_pkg::TagBytes));
            tag_d  = 32'(region_q - RW'(btff_pkg::Overhead));
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_FMT_D;
          end
          btff_pkg::PH_FMT_D: st_d = btff_pkg::ST_IDLE;
          // First-fit walk
          btff_pkg::PH_AL_NEXT: begin
            if (h34 + XW'(btff_pkg::Overhead) > r34) begin
              stat_d = btff_pkg::STAT_NOFIT;
              st_d   = btff_pkg::ST_EMIT;
            end else begin
              addr_d = AW'(h_q);
              st_d   = btff_pkg::ST_RD;
              ph_d   = btff_pkg::PH_AL_T;
            end
          end
          btff_pkg::PH_AL_T: begin
            t_d = mag[RW-1:0];
            if (h34 + XW'(btff_pkg::Overhead) + mag > r34) begin
              stat_d = btff_pkg::STAT_NOFIT;
              st_d   = btff_pkg::ST_EMIT;
            end else if (tv > 0 && tv >= sz34) begin
              addr_d = AW'(h_q);
              st_d   = btff_pkg::ST_WR;
              if (tv - sz34 > XW'(btff_pkg::SplitMin)) begin
                tag_d = 32'(0) - 32'(sz_q);
                ph_d  = btff_pkg::PH_AL_W1;
              end else begin
                tag_d = 32'(0) - tag_q;
                ph_d  = btff_pkg::PH_AL_X1;
              end
            end else begin
              h_d  = RW'(h34 + XW'(btff_pkg::Overhead) + mag);
              ph_d = btff_pkg::PH_AL_NEXT;
            end
          end
          btff_pkg::PH_AL_W1: begin
            addr_d = AW'(h34 + XW'(btff_pkg::TagBytes) + sz34);
            tag_d  = 32'(0) - 32'(sz_q);
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_AL_W2;
          end
          btff_pkg::PH_AL_W2: begin
            addr_d = AW'(h34 + XW'(btff_pkg::Overhead) + sz34);
            tag_d  = diff[31:0];
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_AL_W3;
          end
          btff_pkg::PH_AL_W3: begin
            addr_d = AW'(h34 + XW'(btff_pkg::TagBytes) + t34);
            tag_d  = diff[31:0];
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_AL_X2;
          end
          btff_pkg::PH_AL_X1: begin
            addr_d = AW'(h34 + XW'(btff_pkg::TagBytes) + t34);
            tag_d  = 32'(0) - 32'(t_q);
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_AL_X2;
          end
          btff_pkg::PH_AL_X2: begin
            res_d  = 10'(h_q + RW'(btff_pkg::TagBytes));
            stat_d = btff_pkg::STAT_OK;
            st_d   = btff_pkg::ST_EMIT;
          end
          // Pointer validation
          btff_pkg::PH_PV_GO: begin
            if (h34 + XW'(btff_pkg::TagBytes) > r34) begin
              stat_d = btff_pkg::STAT_BADPTR;
              st_d   = btff_pkg::ST_EMIT;
            end else begin
              addr_d = AW'(h_q);
              st_d   = btff_pkg::ST_RD;
              ph_d   = btff_pkg::PH_PV_H;
            end
          end
          btff_pkg::PH_PV_H: begin
            t_d = mag[RW-1:0];
            if (!tag_q[31] || h34 + XW'(btff_pkg::Overhead) + mag > r34) begin
              stat_d = btff_pkg::STAT_BADPTR;
              st_d   = btff_pkg::ST_EMIT;
            end else begin
              addr_d = AW'(h34 + XW'(btff_pkg::TagBytes) + mag);
              st_d   = btff_pkg::ST_RD;
              ph_d   = btff_pkg::PH_PV_F;
            end
          end
          btff_pkg::PH_PV_F: begin
            s_d = h_q;
            e_d = RW'(h34 + XW'(btff_pkg::Overhead) + t34);
            if (tag_q != 32'(0) - 32'(t_q)) begin
              stat_d = btff_pkg::STAT_BADPTR;
              st_d   = btff_pkg::ST_EMIT;
            end else if (op_q == btff_pkg::FUNC_CHECK) begin
              stat_d = btff_pkg::STAT_OK;
              st_d   = btff_pkg::ST_EMIT;
            end else if (h_q >= RW'(btff_pkg::Overhead)) begin
              addr_d = AW'(h_q - RW'(btff_pkg::TagBytes));
              st_d   = btff_pkg::ST_RD;
              ph_d   = btff_pkg::PH_FR_P;
            end else begin
              ph_d = btff_pkg::PH_FR_NG;
            end
          end
          // Free with coalescing; the previous block must start at or after 0
          btff_pkg::PH_FR_P: begin
            if (tv > 0 && $signed(h34 - XW'(btff_pkg::Overhead) - tv) >= 0)
              s_d = RW'(h34 - XW'(btff_pkg::Overhead) - tv);
            ph_d = btff_pkg::PH_FR_NG;
          end
          btff_pkg::PH_FR_NG: begin
            if (e34 + XW'(btff_pkg::Overhead) <= r34) begin
              addr_d = AW'(e_q);
              st_d   = btff_pkg::ST_RD;
              ph_d   = btff_pkg::PH_FR_N;
            end else begin
              ph_d = btff_pkg::PH_FR_W0;
            end
          end
          btff_pkg::PH_FR_N: begin
            if (tv > 0 && e34 + XW'(btff_pkg::Overhead) + tv <= r34)
              e_d = RW'(e34 + XW'(btff_pkg::Overhead) + tv);
            ph_d = btff_pkg::PH_FR_W0;
          end
          btff_pkg::PH_FR_W0: begin
            addr_d = AW'(s_q);
            tag_d  = 32'(e_q - s_q - RW'(btff_pkg::Overhead));
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_FR_W1;
          end
          btff_pkg::PH_FR_W1: begin
            addr_d = AW'(e_q - RW'(btff_pkg::TagBytes));
            st_d   = btff_pkg::ST_WR;
            ph_d   = btff_pkg::PH_FR_D;
          end
          btff_pkg::PH_FR_D: begin
            stat_d = btff_pkg::STAT_OK;
            st_d   = btff_pkg::ST_EMIT;
          end
          default: st_d = btff_pkg::ST_IDLE;
        endcase
      end
      default: st_d = btff_pkg::ST_IDLE;
    endcase

    // Region register write, clamped, and reformat request
    if (cfg_we_i) begin
      pend_d = 1'b1;
      if (cfg_wdata_i < RW'(btff_pkg::RegionMin))
        region_d = RW'(btff_pkg::RegionMin);
      else if (cfg_wdata_i > RW'(btff_pkg::HeapBytes))
        region_d = RW'(btff_pkg::HeapBytes);
      else
        region_d = cfg_wdata_i;
    end
  end

  // Handshake and memory control
  always_comb begin
    s_axis_tready = (st_q == btff_pkg::ST_IDLE) && !pend_q;
    mem_we    = 1'b0;
    mem_addr  = addr_q + AW'(cnt_q[1:0]);
    mem_wdata = tag_q[8*cnt_q[1:0] +: 8];
    unique case (st_q)
      btff_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      btff_pkg::ST_WR: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  // Byte memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= btff_pkg::ST_CLEAR;
      ph_q     <= btff_pkg::PH_FMT_H;
      cnt_q    <= '0;
      clr_q    <= '0;
      region_q <= RW'(btff_pkg::HeapBytes);
      pend_q   <= 1'b1;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      region_q <= region_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    tag_q   <= tag_d;
    h_q     <= h_d;
    s_q     <= s_d;
    e_q     <= e_d;
    t_q     <= t_d;
    sz_q    <= sz_d;
    op_q    <= op_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    ores_q  <= ores_d;
    ostat_q <= ostat_d;
  end

endmodule
`default_nettype wire

// File: hdl/btff_checker.sv
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module btff_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        cfg_we_i
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status is one of the three codes
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[11:10] != btff_pkg::STAT_NOFIT + 2'd2)
    else $error("bad status code");

  // Failed requests carry no offset
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11:10] != btff_pkg::STAT_OK |-> m_axis_tdata[9:0] == 10'd0)
    else $error("offset on failed request");

  // No request taken at the edge where reset is seen released, as the store clearing starts
  a_clr: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  // A taken request or a region write closes the input for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i || (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input open straight after request or region write");

endmodule

bind boundary_tag_first_fit_allocator btff_sva u_btff_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i)
);
`default_nettype wire

// File: bench/btff_checker.sv
// Checker: watches both streams, predicts each result from a heap model, compares.
`timescale 1ns / 1ps
module btff_checker
  import btff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] offset;
  } outcome_t;

  logic [7:0] heap_mem [HeapBytes];
  int         region;
  outcome_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint tag_rd(longint pos);
    logic [31:0] v;
    if (pos < 0 || pos + TagBytes > HeapBytes) return 0;
    v = {heap_mem[pos+3], heap_mem[pos+2], heap_mem[pos+1], heap_mem[pos]};
    return longint'(signed'(v));
  endfunction

  task automatic tag_wr(longint pos, longint val);
    logic [31:0] v;
    v = val[31:0];
    if (pos < 0 || pos + TagBytes > HeapBytes) return;
    {heap_mem[pos+3], heap_mem[pos+2], heap_mem[pos+1], heap_mem[pos]} = v;
  endtask

  task automatic tags_wr(longint h, longint n, longint val);
    tag_wr(h, val);
    tag_wr(h + TagBytes + n, val);
  endtask

  task automatic format_heap(int r);
    if (r < RegionMin) r = RegionMin;
    if (r > HeapBytes) r = HeapBytes;
    region = r;
    tags_wr(0, r - Overhead, r - Overhead);
  endtask

  function automatic bit owned_ptr(longint p);
    longint h, t;
    h = p - TagBytes;
    if (h < 0 || h + TagBytes > region) return 0;
    t = tag_rd(h);
    if (t >= 0) return 0;
    if (h + Overhead - t > region) return 0;
    return tag_rd(h + TagBytes - t) == t;
  endfunction

  task automatic first_fit(longint sz, output longint r);
    longint h, t, m;
    h = 0;
    r = -1;
    if (sz == 0) return;
    while (h + Overhead <= region) begin
      t = tag_rd(h);
      m = t < 0 ? -t : t;
      if (h + Overhead + m > region) return;
      if (t > 0 && t >= sz) begin
        if (t - sz > SplitMin) begin
          tags_wr(h, sz, -sz);
          tags_wr(h + Overhead + sz, t - sz - Overhead, t - sz - Overhead);
        end else begin
          tags_wr(h, t, -t);
        end
        r = h + TagBytes;
        return;
      end
      h += Overhead + m;
    end
  endtask

  task automatic release_block(longint p);
    longint h, lo, hi, pt, nt;
    h = p - TagBytes;
    lo = h;
    hi = h + Overhead - tag_rd(h);
    if (h >= Overhead) begin
      pt = tag_rd(h - TagBytes);
      if (pt > 0 && h - longint'(Overhead) - pt >= 0) lo = h - longint'(Overhead) - pt;
    end
    if (hi + Overhead <= region) begin
      nt = tag_rd(hi);
      if (nt > 0 && hi + Overhead + nt <= region) hi = hi + Overhead + nt;
    end
    tags_wr(lo, hi - lo - Overhead, hi - lo - Overhead);
  endtask

  task automatic predict(logic [23:0] d);
    outcome_t o;
    longint r;
    o = '{status: STAT_BADPTR, offset: '0};
    case (d[1:0])
      FUNC_ALLOC: begin
        first_fit(d[11:2], r);
        if (r < 0) o.status = STAT_NOFIT;
        else begin
          o.status = STAT_OK;
          o.offset = r[9:0];
        end
      end
      FUNC_FREE: begin
        if (owned_ptr(d[21:12])) begin
          release_block(d[21:12]);
          o.status = STAT_OK;
        end
      end
      FUNC_CHECK: begin
        if (owned_ptr(d[21:12])) o.status = STAT_OK;
      end
      default: ;
    endcase
    expected_q.push_back(o);
  endtask

  // Model update and result comparison on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      foreach (heap_mem[i]) heap_mem[i] = '0;
      format_heap(1024);
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) format_heap(cfg_wdata_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[9:0] !== e.offset) begin
            $error("result_offset: expected %0d actual %0d", e.offset, m_axis_tdata[9:0]);
            fail_count_o <= fail_count_o + 1;
          end else if (m_axis_tdata[11:10] !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, m_axis_tdata[11:10]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata);
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the bench: clock, reset, stimulus for the heap allocator, and the verdict.
`timescale 1ns / 1ps
module testbench;
  import btff_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  int          fail_count;
  int          pending;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_recv = 1'b0;
  int  cycle_count = 0;
  logic [9:0] live_ptrs[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  boundary_tag_first_fit_allocator u_dut (.*);

  btff_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side: random back-pressure, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 10000000) begin
      $display("boundary_tag_first_fit_allocator test failed");
      $finish;
    end
  end

  // Offer one request and wait until it is taken; valid stays up for the next one
  task automatic send(logic [1:0] fn, logic [9:0] sz, logic [9:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, off, sz, fn};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_region(logic [10:0] r);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_ptrs.delete();
  endtask

  // Mostly well-formed alloc/free traffic with some noise
  task automatic random_ops(int n, int max_sz);
    int k;
    logic [9:0] p;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 45) begin
        send(FUNC_ALLOC, ($urandom_range(9) == 0) ? 10'($urandom) :
             10'($urandom_range(max_sz)), 10'($urandom));
      end else if (k < 80 && live_ptrs.size() != 0) begin
        p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
        send(($urandom_range(1) == 0) ? FUNC_FREE : FUNC_CHECK, 10'($urandom), p);
      end else begin
        send(2'($urandom), 10'($urandom), 10'($urandom));
      end
    end
  endtask

  // Record handed-out offsets so frees usually hit real blocks
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tdata[11:10] == STAT_OK &&
        m_axis_tdata[9:0] != 0)
      live_ptrs.push_back(m_axis_tdata[9:0]);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edge sizes, every operation, bad pointers
    send(FUNC_ALLOC, 10'd0, 10'd0);
    send(FUNC_ALLOC, 10'd1016, 10'd0);
    send(FUNC_CHECK, 10'd0, 10'd4);
    send(FUNC_FREE, 10'd0, 10'd4);
    send(FUNC_ALLOC, 10'd1023, 10'd0);
    send(FUNC_ALLOC, 10'd16, 10'd0);
    send(FUNC_ALLOC, 10'd16, 10'd0);
    send(FUNC_ALLOC, 10'd16, 10'd0);
    send(FUNC_FREE, 10'd0, 10'd28);
    send(FUNC_FREE, 10'd0, 10'd4);
    send(FUNC_FREE, 10'd0, 10'd52);
    send(FUNC_CHECK, 10'd0, 10'd0);
    send(FUNC_CHECK, 10'd0, 10'd1023);
    send(2'd3, 10'h3ff, 10'h3ff);
    send(FUNC_ALLOC, 10'd1000, 10'd0);
    send(FUNC_ALLOC, 10'd8, 10'd0);
    send(FUNC_FREE, 10'd0, 10'd4);

    set_region(11'd16);
    send(FUNC_ALLOC, 10'd8, 10'd0);
    send(FUNC_ALLOC, 10'd1, 10'd0);
    send(FUNC_FREE, 10'd0, 10'd4);
    send(FUNC_ALLOC, 10'd1, 10'd0);
    set_region(11'd0);
    send(FUNC_ALLOC, 10'd8, 10'd0);
    set_region(11'h7ff);
    send(FUNC_CHECK, 10'd0, 10'd4);

    // Random phases under changing idling and region sizes
    send_idle_pct = 34; recv_idle_pct = 58;
    random_ops(300, 120);
    set_region(11'd200);
    send_idle_pct = 58; recv_idle_pct = 34;
    random_ops(300, 60);
    set_region(11'd1024);
    send_idle_pct = 0; recv_idle_pct = 0;

    // Long receiver hold-off while requests keep coming
    hold_recv = 1'b1;
    fork
      random_ops(20, 100);
      begin
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
    join
    drain();
    set_region(11'd512);
    random_ops(300, 200);
    set_region(11'd1024);
    random_ops(260, 300);
    drain();

    if (fail_count == 0) $display("boundary_tag_first_fit_allocator test passed");
    else $display("boundary_tag_first_fit_allocator test failed");
    $finish;
  end

endmodule
